### rtl/mm3_pkg.sv
// Shared types, constants and helper functions for the MurmurHash3 byte stream hash.
// Used by mm3_front, mm3_back and murmur3_byte_stream_hash_core; depends on nothing else.
`default_nettype none

package mm3_pkg;

  // Seed value loaded at reset.
  localparam logic [31:0] SEED_RESET = 32'h811c9dc5;

  // Block scrambling and mixing constants.
  localparam logic [31:0] MIX_C1  = 32'hcc9e2d51;
  localparam logic [31:0] MIX_C2  = 32'h1b873593;
  localparam logic [31:0] MIX_ADD = 32'he6546b64;

  // Final avalanche constants.
  localparam logic [31:0] FIN_C1 = 32'h85ebca6b;
  localparam logic [31:0] FIN_C2 = 32'hc2b2ae35;

  // Request queue between front and back; the depth must be a power of two.
  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // One queued request.
  typedef struct packed {
    logic [7:0] key_byte;
    logic       has_byte;
    logic       is_last;
  } item_t;

  // Back-end sequencer states.
  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_K1   = 8'b0000_0010,
    ST_K2   = 8'b0000_0100,
    ST_HMIX = 8'b0000_1000,
    ST_FIN  = 8'b0001_0000,
    ST_F1   = 8'b0010_0000,
    ST_F2   = 8'b0100_0000,
    ST_OUT  = 8'b1000_0000
  } state_t;

  // Rotate left by 15 bits.
  function automatic logic [31:0] rotl15(input logic [31:0] v);
    rotl15 = {v[16:0], v[31:17]};
  endfunction

  // Rotate left by 13 bits.
  function automatic logic [31:0] rotl13(input logic [31:0] v);
    rotl13 = {v[18:0], v[31:19]};
  endfunction

endpackage

`default_nettype wire

### rtl/mm3_front.sv
// Front end: accepts input requests, drops requests that carry neither a byte nor an end
// mark, and queues the rest for the back end. Depends on mm3_pkg.
`default_nettype none

module mm3_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire logic [7:0]     in_key_byte,
  input  wire logic           in_has_byte,
  input  wire logic           in_is_last,
  output mm3_pkg::item_t      head,
  output logic                head_valid,
  input  wire logic           pop
);

  mm3_pkg::item_t                q_r [mm3_pkg::QDEPTH];
  logic [mm3_pkg::QAW-1:0]       wptr_r, wptr_nxt;
  logic [mm3_pkg::QAW-1:0]       rptr_r, rptr_nxt;
  logic [mm3_pkg::QCW-1:0]       cnt_r, cnt_nxt;
  logic                          accept;
  logic                          push;
  logic                          do_pop;
  mm3_pkg::item_t                new_item;

  // The queue holds back new requests only when it is full.
  assign in_stall   = (cnt_r == mm3_pkg::QCW'(mm3_pkg::QDEPTH));
  assign accept     = in_valid && !in_stall;
  assign head_valid = (cnt_r != '0);
  assign head       = q_r[rptr_r];
  assign do_pop     = pop && head_valid;

  // Requests with no byte and no end mark change nothing, so they are not queued.
  assign push = accept && (in_has_byte || in_is_last);

  always_comb begin
    new_item.key_byte = in_key_byte;
    new_item.has_byte = in_has_byte;
    new_item.is_last  = in_is_last;
  end

  // Pointer and fill count update.
  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = wptr_r + mm3_pkg::QAW'(1);
    end
    if (do_pop) begin
      rptr_nxt = rptr_r + mm3_pkg::QAW'(1);
    end
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + mm3_pkg::QCW'(1);
    end else if (!push && do_pop) begin
      cnt_nxt = cnt_r - mm3_pkg::QCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wptr_r] <= new_item;
    end
  end

endmodule

`default_nettype wire

### rtl/mm3_back.sv
// Back end: packs bytes into blocks, mixes blocks, finishes keys and drives the result
// register. One shared 32-bit multiplier serves the scramble and finalisation constant multiplies. Depends on mm3_pkg.
`default_nettype none

module mm3_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire mm3_pkg::item_t head,
  input  wire logic           head_valid,
  output logic                pop,
  input  wire logic           cfg_we,
  input  wire logic [31:0]    cfg_wdata,
  output logic                out_valid,
  input  wire logic           out_stall,
  output logic [31:0]         out_hash_value
);

  mm3_pkg::state_t state_r, state_nxt;
  logic [31:0] seed_r, seed_nxt;
  logic [31:0] hash_r, hash_nxt;
  logic [23:0] partial_r, partial_nxt;
  logic [1:0]  pos_r, pos_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] k_r, k_nxt;
  logic [31:0] f_r, f_nxt;
  logic        tail_r, tail_nxt;
  logic        last_r, last_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_hash_r, out_hash_nxt;
  logic [31:0] mul_a, mul_b;
  logic [31:0] mul_p;
  logic [31:0] mix_rot;
  logic [31:0] mix_h;

  assign out_valid      = out_valid_r;
  assign out_hash_value = out_hash_r;

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = k_r;
    mul_b = mm3_pkg::MIX_C1;
    case (state_r)
      mm3_pkg::ST_K2: begin
        mul_a = mm3_pkg::rotl15(k_r);
        mul_b = mm3_pkg::MIX_C2;
      end
      mm3_pkg::ST_F1: begin
        mul_a = f_r ^ (f_r >> 16);
        mul_b = mm3_pkg::FIN_C1;
      end
      mm3_pkg::ST_F2: begin
        mul_a = f_r ^ (f_r >> 13);
        mul_b = mm3_pkg::FIN_C2;
      end
      default: begin
      end
    endcase
  end

  // Only the low 32 bits of the product are needed.
  assign mul_p = mul_a * mul_b;

  // Running hash update for a full block: rotate, then multiply by five and add.
  assign mix_rot = mm3_pkg::rotl13(hash_r ^ k_r);
  assign mix_h   = (mix_rot << 2) + mix_rot + mm3_pkg::MIX_ADD;

  // Sequencer and state update.
  always_comb begin
    state_nxt     = state_r;
    seed_nxt      = seed_r;
    hash_nxt      = hash_r;
    partial_nxt   = partial_r;
    pos_nxt       = pos_r;
    len_nxt       = len_r;
    k_nxt         = k_r;
    f_nxt         = f_r;
    tail_nxt      = tail_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r;
    out_hash_nxt  = out_hash_r;
    pop           = 1'b0;

    // The result register empties when the receiver takes it.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      mm3_pkg::ST_IDLE: begin
        if (head_valid) begin
          pop = 1'b1;
          if (head.has_byte) begin
            len_nxt = len_r + 32'd1;
            if (pos_r == 2'd3) begin
              // Fourth byte completes a block.
              k_nxt     = {head.key_byte, partial_r};
              tail_nxt  = 1'b0;
              last_nxt  = head.is_last;
              state_nxt = mm3_pkg::ST_K1;
            end else begin
              partial_nxt = partial_r | (24'(head.key_byte) << {pos_r, 3'b000});
              pos_nxt     = pos_r + 2'd1;
              if (head.is_last) begin
                state_nxt = mm3_pkg::ST_FIN;
              end
            end
          end else if (head.is_last) begin
            state_nxt = mm3_pkg::ST_FIN;
          end
        end
      end
      mm3_pkg::ST_K1: begin
        k_nxt     = mul_p;
        state_nxt = mm3_pkg::ST_K2;
      end
      mm3_pkg::ST_K2: begin
        k_nxt     = mul_p;
        state_nxt = mm3_pkg::ST_HMIX;
      end
      mm3_pkg::ST_HMIX: begin
        if (tail_r) begin
          // Scrambled tail goes straight into the finalisation value.
          f_nxt     = hash_r ^ k_r ^ len_r;
          state_nxt = mm3_pkg::ST_F1;
        end else begin
          hash_nxt    = mix_h;
          partial_nxt = '0;
          pos_nxt     = '0;
          state_nxt   = last_r ? mm3_pkg::ST_FIN : mm3_pkg::ST_IDLE;
        end
      end
      mm3_pkg::ST_FIN: begin
        if (pos_r != 2'd0) begin
          k_nxt     = {8'd0, partial_r};
          tail_nxt  = 1'b1;
          state_nxt = mm3_pkg::ST_K1;
        end else begin
          f_nxt     = hash_r ^ len_r;
          state_nxt = mm3_pkg::ST_F1;
        end
      end
      mm3_pkg::ST_F1: begin
        f_nxt     = mul_p;
        state_nxt = mm3_pkg::ST_F2;
      end
      mm3_pkg::ST_F2: begin
        f_nxt     = mul_p;
        state_nxt = mm3_pkg::ST_OUT;
      end
      mm3_pkg::ST_OUT: begin
        // Hand over the hash once the result register is free, then restart the key.
        if (!out_valid_r || !out_stall) begin
          out_hash_nxt  = f_r ^ (f_r >> 16);
          out_valid_nxt = 1'b1;
          hash_nxt      = seed_r;
          partial_nxt   = '0;
          pos_nxt       = '0;
          len_nxt       = '0;
          tail_nxt      = 1'b0;
          state_nxt     = mm3_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mm3_pkg::ST_IDLE;
      end
    endcase

    // A seed write also reloads the running hash when no byte of a key is held.
    if (cfg_we) begin
      seed_nxt = cfg_wdata;
      if ((len_r == 32'd0) && (pos_r == 2'd0)) begin
        hash_nxt = cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mm3_pkg::ST_IDLE;
      seed_r      <= mm3_pkg::SEED_RESET;
      hash_r      <= mm3_pkg::SEED_RESET;
      partial_r   <= '0;
      pos_r       <= '0;
      len_r       <= '0;
      tail_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seed_r      <= seed_nxt;
      hash_r      <= hash_nxt;
      partial_r   <= partial_nxt;
      pos_r       <= pos_nxt;
      len_r       <= len_nxt;
      tail_r      <= tail_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    f_r        <= f_nxt;
    last_r     <= last_nxt;
    out_hash_r <= out_hash_nxt;
  end

endmodule

`default_nettype wire

### rtl/murmur3_byte_stream_hash_core.sv
// MurmurHash3 x86 32-bit hash core, top level.
// Instantiates mm3_front and mm3_back; depends on mm3_pkg.
//
// Usage: the key enters one byte per request on the in_ channel (valid/stall).
// in_has_byte marks a request that carries in_key_byte; in_is_last ends the key
// and causes one hash on the out_ channel. A request with neither bit set is
// taken and ignored. Bytes are queued in a two-entry request queue ahead of a
// sequencer built round one shared 32-bit multiplier.
// A byte that does not complete a block is handled in the idle state; a byte
// that completes a four-byte block also passes through states K1 and K2 (two
// scramble multiplies) and HMIX (the hash update). Ending a key passes through
// FIN, F1, F2 and OUT, with K1, K2 and HMIX after FIN for a one to three byte
// tail, before the hash is loaded into the output register.
// The seed register is written through cfg_we/cfg_wdata; the user must do so
// only while the core is idle, which the core itself does not enforce.
// Reset loads the default seed and empties the queue and the output register.
// While the receiver stalls, the finished hash stays put; the core keeps taking
// bytes of the next key until it needs the output register again.
`default_nettype none

module murmur3_byte_stream_hash_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_key_byte,
  input  wire logic        in_has_byte,
  input  wire logic        in_is_last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_hash_value,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata
);

  mm3_pkg::item_t head;
  logic           head_valid;
  logic           pop;

  // Request intake and queue.
  mm3_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_key_byte(in_key_byte),
    .in_has_byte(in_has_byte),
    .in_is_last (in_is_last),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop)
  );

  // Hash sequencer and result register.
  mm3_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (head),
    .head_valid    (head_valid),
    .pop           (pop),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_hash_value(out_hash_value)
  );

endmodule

`default_nettype wire
